// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GKW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gkw check failed");

// The consequent must hold in the cycle after the antecedent.
`define GKW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gkw check failed");

`endif

// ===== rtl/gkw_pkg.sv =====
// Types, constants and helper functions of the Gaussian kernel weight generator.
`timescale 1ns / 1ps
package gkw_pkg;
	localparam int DIV_W = 42;
	localparam int DIVISOR_W = 32;
	localparam int MUL_W = 31;
	localparam int PROD_W = 2 * MUL_W;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [23:0] RAW_ONE = 24'h80_0000;
	localparam logic [DIV_W-1:0] EXP_CUTOFF = DIV_W'(17) << 16;
	localparam logic [15:0] W_MAX = 16'hFFFF;
	// Reciprocal of three scaled by 2^30, exact for dividends below 2^29.
	localparam logic [30:0] RECIP3 = 31'h1555_5556;

	typedef logic [PROD_W-1:0] prod_t;

	function automatic logic [31:0] round_q30(input prod_t p);
		prod_t s;
		s = p + (PROD_W'(1) << 29);
		return 32'(s >> 30);
	endfunction
endpackage

// ===== rtl/gkw_if.sv =====
// Valid/ready channel interfaces for kernel requests and tap results.
`timescale 1ns / 1ps
interface gkw_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] sigma;
	logic [4:0]  radius;
	modport source(output valid, sigma, radius, input ready);
	modport sink(input valid, sigma, radius, output ready);
endinterface

interface gkw_rsp_if;
	logic        valid;
	logic        ready;
	logic [5:0]  tap_index;
	logic [15:0] weight;
	logic        last_tap;
	modport source(output valid, tap_index, weight, last_tap, input ready);
	modport sink(input valid, tap_index, weight, last_tap, output ready);
endinterface

// ===== rtl/gaussian_kernel_weights.sv =====
// Top level of the normalized one-dimensional Gaussian kernel generator.
// The req channel takes a sigma (unsigned Q8.8) and a radius r; a radius above
// MAX_RADIUS is treated as MAX_RADIUS. The rsp channel then gives 2r+1 taps in
// order of distance r down to 0 and back up to r, each with its index, its
// Q0.16 weight and a last_tap flag on the final one.
// One shared multiplier and one bit-per-cycle divider do all arithmetic under
// a sequencer. Each nonzero distance, if sigma is nonzero, takes one division
// for the exponent and, below the cutoff, the series, with the division by
// three as a reciprocal multiply and the eight squarings; every distance then
// adds to the sum. Each tap then takes a normalizing division; the divider
// sets the run time of a full kernel.
// req.ready is high only while the block is idle, so one kernel is worked on
// at a time. Each tap waits in an output register until it is taken; a stall
// on rsp holds the tap and the sequencer. After reset the block is idle and
// ready, with no tap pending.
`timescale 1ns / 1ps
module gaussian_kernel_weights
	import gkw_pkg::*;
#(
	parameter int MAX_RADIUS = 31
) (
	input logic       clk,
	input logic       arst_n,
	gkw_req_if.sink   req,
	gkw_rsp_if.source rsp
);
	localparam int DEPTH = MAX_RADIUS + 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_N    = 4'd2;
	localparam logic [3:0] S_DIV1 = 4'd3;
	localparam logic [3:0] S_M1   = 4'd4;
	localparam logic [3:0] S_DIV3 = 4'd5;
	localparam logic [3:0] S_M2   = 4'd6;
	localparam logic [3:0] S_M3   = 4'd7;
	localparam logic [3:0] S_SQR  = 4'd8;
	localparam logic [3:0] S_RAW  = 4'd9;
	localparam logic [3:0] S_ACC  = 4'd10;
	localparam logic [3:0] S_RD   = 4'd11;
	localparam logic [3:0] S_DV   = 4'd12;
	localparam logic [3:0] S_DIVN = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	logic [3:0]  state_q;
	logic [15:0] sigma_q;
	logic [4:0]  r_q;
	logic [4:0]  n_q;
	logic [5:0]  k_q;
	logic [2:0]  sqr_cnt_q;
	logic [31:0] sq_q;
	logic [30:0] y_q;
	logic [30:0] p_q;
	logic [23:0] raw_q;
	logic [31:0] sum_q;
	logic [23:0] rdata_q;
	logic [23:0] raw_mem [DEPTH];
	logic        valid_q;
	logic [5:0]  tap_q;
	logic [15:0] weight_q;
	logic        last_q;

	logic [4:0]           r_eff;
	logic [9:0]           nsq;
	logic [5:0]           tap_dist;
	logic [MUL_W-1:0]     mul_a;
	logic [MUL_W-1:0]     mul_b;
	prod_t                prod;
	logic [31:0]          rnd;
	logic                 div_start;
	logic [DIV_W-1:0]     div_dvd;
	logic [DIVISOR_W-1:0] div_dsr;
	logic                 div_done;
	logic [DIV_W-1:0]     div_q;
	logic [31:0]          raw_pre;

	assign r_eff = (req.radius > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : req.radius;
	assign nsq = 10'(n_q) * 10'(n_q);
	assign tap_dist = (k_q <= 6'(r_q)) ? 6'(r_q) - k_q : k_q - 6'(r_q);
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign rnd = round_q30(prod);
	assign raw_pre = (32'(p_q) + 32'd64) >> 7;

	always_comb begin
		mul_a = p_q;
		mul_b = p_q;
		div_start = 1'b0;
		div_dvd = DIV_W'(nsq) << 31;
		div_dsr = sq_q;
		unique case (state_q)
			S_SQ: begin
				mul_a = MUL_W'(sigma_q);
				mul_b = MUL_W'(sigma_q);
			end
			S_N: begin
				div_start = (n_q != '0) && (sigma_q != '0);
			end
			S_M1: begin
				mul_a = y_q;
			end
			S_DIV3: begin
				mul_b = RECIP3;
			end
			S_M2, S_M3: begin
				mul_a = y_q;
			end
			S_DV: begin
				div_start = 1'b1;
				div_dvd = (DIV_W'(rdata_q) << 16) + DIV_W'(sum_q >> 1);
				div_dsr = sum_q;
			end
			default: begin
				mul_a = p_q;
			end
		endcase
	end

	gkw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			n_q <= '0;
			k_q <= '0;
			sqr_cnt_q <= '0;
			sum_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_SQ;
						n_q <= '0;
						sum_q <= '0;
					end
				end
				S_SQ: state_q <= S_N;
				S_N: begin
					if ((n_q == '0) || (sigma_q == '0)) begin
						state_q <= S_ACC;
					end else begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= (div_q >= EXP_CUTOFF) ? S_ACC : S_M1;
					end
				end
				S_M1: state_q <= S_DIV3;
				S_DIV3: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: begin
					state_q <= S_SQR;
					sqr_cnt_q <= '0;
				end
				S_SQR: begin
					sqr_cnt_q <= sqr_cnt_q + 1'b1;
					if (sqr_cnt_q == 3'd7) begin
						state_q <= S_RAW;
					end
				end
				S_RAW: state_q <= S_ACC;
				S_ACC: begin
					sum_q <= sum_q + ((n_q == '0) ? 32'(raw_q) : (32'(raw_q) << 1));
					if (n_q == r_q) begin
						state_q <= S_RD;
						k_q <= '0;
					end else begin
						n_q <= n_q + 1'b1;
						state_q <= S_N;
					end
				end
				S_RD: state_q <= S_DV;
				S_DV: state_q <= S_DIVN;
				S_DIVN: begin
					if (div_done) begin
						state_q <= S_OUT;
						valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						valid_q <= 1'b0;
						if (k_q == {r_q, 1'b0}) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			sigma_q <= req.sigma;
			r_q <= r_eff;
		end
		if (state_q == S_SQ) begin
			sq_q <= prod[31:0];
		end
		if (state_q == S_N) begin
			raw_q <= (n_q == '0) ? RAW_ONE : '0;
		end
		if ((state_q == S_DIV1) && div_done) begin
			y_q <= 31'(div_q[20:0]) << 6;
			p_q <= Q30_ONE - (31'(div_q[20:0]) << 4);
		end
		if (state_q == S_M1) begin
			p_q <= rnd[30:0];
		end
		if (state_q == S_DIV3) begin
			p_q <= Q30_ONE - 31'(prod >> 30);
		end
		if (state_q == S_M2) begin
			p_q <= Q30_ONE - 31'(rnd >> 1);
		end
		if (state_q == S_M3) begin
			p_q <= Q30_ONE - rnd[30:0];
		end
		if (state_q == S_SQR) begin
			p_q <= rnd[30:0];
		end
		if (state_q == S_RAW) begin
			raw_q <= (raw_pre > 32'(RAW_ONE)) ? RAW_ONE : raw_pre[23:0];
		end
		if ((state_q == S_DIVN) && div_done) begin
			tap_q <= k_q;
			last_q <= (k_q == {r_q, 1'b0});
			weight_q <= (div_q > DIV_W'(W_MAX)) ? W_MAX : div_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACC) begin
			raw_mem[n_q[AW-1:0]] <= raw_q;
		end
		rdata_q <= raw_mem[tap_dist[AW-1:0]];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = valid_q;
	assign rsp.tap_index = tap_q;
	assign rsp.weight = weight_q;
	assign rsp.last_tap = last_q;
endmodule

// ===== rtl/gkw_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module gkw_div
	import gkw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_W-1:0]     quotient
);
	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic                 ge;

	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign ge = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DIVISOR_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
endmodule

// ===== rtl/gkw_checker.sv =====
// Port-level checks of the Gaussian kernel weight generator and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gkw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [5:0]  rsp_tap_index,
	input logic [15:0] rsp_weight,
	input logic        rsp_last_tap
);
	logic rsp_stall;
	logic rsp_xfer;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	`GKW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_tap_index) && $stable(rsp_weight) && $stable(rsp_last_tap))
	`GKW_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`GKW_ASSERT_SAME(a_no_req_while_tap, clk, arst_n, rsp_valid, !req_ready)
	`GKW_ASSERT_NEXT(a_gap_after_tap, clk, arst_n, rsp_xfer && !rsp_last_tap, !rsp_valid && !req_ready)
endmodule

bind gaussian_kernel_weights gkw_checker u_gkw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_tap_index (rsp.tap_index),
	.rsp_weight    (rsp.weight),
	.rsp_last_tap  (rsp.last_tap)
);

// ===== test/tb_gaussian_kernel_weights.sv =====
// Testbench of the Gaussian kernel weight generator: directed and random kernels checked per tap.
`timescale 1ns / 1ps
module tb_gaussian_kernel_weights;
	import gkw_pkg::*;

	localparam int RMAX = 31;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic [5:0]  tap_index;
		logic [15:0] weight;
		logic        last_tap;
	} tap_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   idle_cycles;
	tap_t expected_taps[$];

	gkw_req_if req();
	gkw_rsp_if rsp();

	gaussian_kernel_weights #(.MAX_RADIUS(RMAX)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b + (128'(1) << 29);
		return 64'(p >> 30);
	endfunction

	function automatic logic [23:0] gauss_raw(logic [15:0] sigma, int n);
		logic [63:0] sq, xq, y, p;
		if (n == 0) return 24'h80_0000;
		if (sigma == 0) return 24'd0;
		sq = 64'(sigma) * 64'(sigma);
		xq = ((64'(n) * 64'(n)) << 31) / sq;
		if (xq >= (64'd17 << 16)) return 24'd0;
		y = xq << 6;
		p = (64'd1 << 30) - y / 4;
		p = (64'd1 << 30) - q30_mul(y, p) / 3;
		p = (64'd1 << 30) - q30_mul(y, p) / 2;
		p = (64'd1 << 30) - q30_mul(y, p);
		for (int i = 0; i < 8; i++) p = q30_mul(p, p);
		p = (p + 64) >> 7;
		if (p > 64'h80_0000) p = 64'h80_0000;
		return 24'(p);
	endfunction

	task automatic predict_kernel(logic [15:0] sigma, logic [4:0] radius);
		logic [23:0] raw[RMAX+1];
		logic [31:0] total;
		logic [63:0] w;
		int r, d;
		tap_t t;
		r = (radius > RMAX) ? RMAX : radius;
		total = 0;
		for (int n = 0; n <= r; n++) begin
			raw[n] = gauss_raw(sigma, n);
			total += (n == 0 ? 32'd1 : 32'd2) * raw[n];
		end
		for (int k = 0; k < 2 * r + 1; k++) begin
			d = (k <= r) ? r - k : k - r;
			w = 0;
			if (total != 0) begin
				w = ((64'(raw[d]) << 16) + total / 2) / total;
				if (w > 64'd65535) w = 64'd65535;
			end
			t.tap_index = 6'(k);
			t.weight = 16'(w);
			t.last_tap = (k == 2 * r);
			expected_taps.push_back(t);
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_kernel(logic [15:0] sigma, logic [4:0] radius, bit gaps = 1);
		@(negedge clk);
		if (gaps) repeat (gap_len()) @(negedge clk);
		req.valid <= 1'b1;
		req.sigma <= sigma;
		req.radius <= radius;
		do @(posedge clk); while (!req.ready);
		predict_kernel(sigma, radius);
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_taps.size() != 0) @(negedge clk);
	endtask

	task automatic test_extremes();
		send_kernel(16'd0, 5'd0);
		send_kernel(16'd0, 5'd31);
		send_kernel(16'd0, 5'd3);
		send_kernel(16'hFFFF, 5'd31);
		send_kernel(16'hFFFF, 5'd0);
		send_kernel(16'd1, 5'd31);
		send_kernel(16'd1, 5'd1);
		send_kernel(16'h0100, 5'd4);
		send_kernel(16'h0080, 5'd2);
		send_kernel(16'h0300, 5'd8);
		send_kernel(16'hAAAA, 5'd21);
		send_kernel(16'h5555, 5'd10);
		send_kernel(16'h0200, 5'd31);
	endtask

	task automatic test_drained_pause();
		wait_drained();
		send_kernel(16'h0180, 5'd5, 0);
		wait_drained();
		send_kernel(16'h0040, 5'd16, 0);
	endtask

	task automatic test_random();
		logic [15:0] s;
		logic [4:0] r;
		for (int i = 0; i < 365; i++) begin
			case ($urandom_range(0, 3))
				0: s = 16'($urandom);
				1: s = 16'($urandom_range(0, 16'h0400));
				2: s = 16'($urandom_range(0, 16));
				default: s = 16'($urandom_range(16'h0040, 16'h1000));
			endcase
			r = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
			send_kernel(s, r, $urandom_range(0, 3) != 0);
		end
	endtask

	always @(negedge clk) begin
		if ($urandom_range(0, 2) == 0) rsp.ready <= ($urandom_range(0, 9) < 4);
		else rsp.ready <= 1'b1;
	end

	always @(posedge clk) begin
		tap_t got, exp_tap;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.tap_index = rsp.tap_index;
			got.weight = rsp.weight;
			got.last_tap = rsp.last_tap;
			if (expected_taps.size() == 0) begin
				$error("unexpected tap index %0d", got.tap_index);
				errors++;
			end else begin
				exp_tap = expected_taps.pop_front();
				if (got.tap_index !== exp_tap.tap_index) begin
					$error("tap_index expected %0d actual %0d", exp_tap.tap_index, got.tap_index);
					errors++;
				end
				if (got.weight !== exp_tap.weight) begin
					$error("weight expected %0d actual %0d", exp_tap.weight, got.weight);
					errors++;
				end
				if (got.last_tap !== exp_tap.last_tap) begin
					$error("last_tap expected %0d actual %0d", exp_tap.last_tap, got.last_tap);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.sigma = '0;
		req.radius = '0;
		rsp.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_drained_pause();
		test_random();
		wait_drained();
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_taps.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
